// ===== rtl/core/image_line_road_plane_intersect_unit_macros.svh =====
// Assertion helpers for the line/plane intersection block.
`ifndef IMAGE_LINE_ROAD_PLANE_INTERSECT_UNIT_MACROS_SVH
`define IMAGE_LINE_ROAD_PLANE_INTERSECT_UNIT_MACROS_SVH

// antecedent and consequent in the same cycle
`define ILRP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ilrp: same-cycle check failed");

// consequent in the cycle after the antecedent
`define ILRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ilrp: next-cycle check failed");

`endif

// ===== rtl/core/ilrp_pkg.sv =====
package ilrp_pkg;

    typedef logic signed [63:0] t_q;

    typedef struct packed {
        t_q   v;
        logic sat;
    } t_qres;

    localparam t_q Q_MAX = 64'sh7fff_ffff_ffff_ffff;
    localparam t_q Q_MIN = 64'sh8000_0000_0000_0000;

    localparam int NUM_REGS = 7;
    localparam logic [2:0] REG_FOCAL_X  = 3'd0;
    localparam logic [2:0] REG_FOCAL_Y  = 3'd1;
    localparam logic [2:0] REG_CENTER_X = 3'd2;
    localparam logic [2:0] REG_CENTER_Y = 3'd3;
    localparam logic [2:0] REG_CAMERA_X = 3'd4;
    localparam logic [2:0] REG_CAMERA_Y = 3'd5;
    localparam logic [2:0] REG_CAMERA_Z = 3'd6;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_PARALLEL = 2'd1;
    localparam logic [1:0] ST_SAT      = 2'd2;

    // register reset values in whole units
    localparam int K_FOCAL    = 100;
    localparam int K_CENTER_X = 100;
    localparam int K_CENTER_Y = 50;
    localparam int K_CAMERA_Z = 1;

    // per-item working set carried down the arithmetic stages
    typedef struct packed {
        t_q   a, b, c, off;
        t_q   q0, q1, q2;
        t_q   p0, p1, p2;
        t_q   tp, pp, pq, qq;
        t_q   e0, e1, e2, e3;
        t_q   d0, d1, d2;
        t_q   b0, b1;
        t_q   det, s0, s1;
        t_q   n0, n1, n2;
        logic sat;
        logic par;
    } t_ctx;

    // what rides alongside the dividers
    typedef struct packed {
        t_q          d0, d1, d2;
        logic [63:0] ud;
        logic [2:0]  neg;
        logic        sat;
        logic        par;
    } t_tail;

    function automatic logic [63:0] magn(t_q x);
        return x[63] ? (~x + 64'd1) : x;
    endfunction

    function automatic t_qres from_mag(logic neg, logic [63:0] m);
        t_qres r;
        r.sat = 1'b0;
        if (!neg) begin
            if (m[63]) begin
                r.v   = Q_MAX;
                r.sat = 1'b1;
            end else begin
                r.v = m;
            end
        end else begin
            if (m > 64'h8000_0000_0000_0000) begin
                r.v   = Q_MIN;
                r.sat = 1'b1;
            end else begin
                r.v = ~m + 64'd1;
            end
        end
        return r;
    endfunction

    function automatic t_qres qadd(t_q x, t_q y);
        t_qres r;
        logic signed [64:0] s;
        s     = 65'(x) + 65'(y);
        r.sat = s[64] != s[63];
        r.v   = r.sat ? (s[64] ? Q_MIN : Q_MAX) : s[63:0];
        return r;
    endfunction

    function automatic t_qres qsub(t_q x, t_q y);
        t_qres r;
        logic signed [64:0] s;
        s     = 65'(x) - 65'(y);
        r.sat = s[64] != s[63];
        r.v   = r.sat ? (s[64] ? Q_MIN : Q_MAX) : s[63:0];
        return r;
    endfunction

    function automatic t_qres qneg(t_q x);
        return qsub('0, x);
    endfunction

endpackage

// ===== rtl/core/ilrp_qmul.sv =====
// Q-format multiply, 64x64 from four 32x32 partial products, three stages.
module ilrp_qmul import ilrp_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic i_clk,
    input  logic i_en,
    input  t_q   i_a,
    input  t_q   i_b,
    output t_q   o_p,
    output logic o_sat
);

    logic          r_neg1, r_neg2;
    logic [63:0]   r_ma, r_mb;
    logic [63:0]   r_p00, r_p01, r_p10, r_p11;
    logic [127:0]  n_full, n_sh;
    t_qres         n_res;
    t_q            r_p;
    logic          r_sat;

    always_comb begin
        n_full = {64'd0, r_p00} + {32'd0, r_p01, 32'd0} + {32'd0, r_p10, 32'd0}
               + {r_p11, 64'd0} + (128'd1 << (FRAC_BITS - 1));
        n_sh   = n_full >> FRAC_BITS;
        if (|n_sh[127:64]) begin
            n_res.v   = r_neg2 ? Q_MIN : Q_MAX;
            n_res.sat = 1'b1;
        end else begin
            n_res = from_mag(r_neg2, n_sh[63:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg1 <= i_a[63] ^ i_b[63];
            r_ma   <= magn(i_a);
            r_mb   <= magn(i_b);
            r_neg2 <= r_neg1;
            r_p00  <= r_ma[31:0]  * r_mb[31:0];
            r_p01  <= r_ma[31:0]  * r_mb[63:32];
            r_p10  <= r_ma[63:32] * r_mb[31:0];
            r_p11  <= r_ma[63:32] * r_mb[63:32];
            r_p    <= n_res.v;
            r_sat  <= n_res.sat;
        end
    end

    assign o_p   = r_p;
    assign o_sat = r_sat;

endmodule

// ===== rtl/core/image_line_road_plane_intersect_unit.sv =====
// Channel   Dir  Handshake                      Payload
// cfg       in   i_cfg_we                       i_cfg_idx, i_cfg_data
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready line a,b,c, plane nx,ny,nz,offset
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready dir xyz, point xyz, status
//
// One item per cycle sustained while the output is not stalled; default format Q16.16.
// The dividers are restoring, one quotient bit per stage, 64 + FRAC_BITS stages.
// Multiplies take three stages each, four multiply levels in series.
// Synchronous active-low reset clears valid bits and the registers to their defaults.
// Stall is global: the whole pipe holds while the output item is waiting,
// and moves whenever the output stage is empty or being taken.
`include "image_line_road_plane_intersect_unit_macros.svh"

module image_line_road_plane_intersect_unit import ilrp_pkg::*; #(
    parameter  int WORD_BITS = 32,
    parameter  int FRAC_BITS = 16,
    localparam int IN_BITS   = ((7 * WORD_BITS + 7) / 8) * 8,
    localparam int OUT_BITS  = ((6 * WORD_BITS + 2 + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [WORD_BITS-1:0] i_cfg_data,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // line_a, line_b, line_c, plane_nx, plane_ny, plane_nz, plane_offset
    input  logic [IN_BITS-1:0]   i_s_axis_tdata,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // dir_x, dir_y, dir_z, point_x, point_y, point_z, status
    output logic [OUT_BITS-1:0]  o_m_axis_tdata
);

    localparam int DIV_STEPS = 64 + FRAC_BITS;
    localparam int NST       = 24 + DIV_STEPS;

    function automatic t_q sx(logic signed [WORD_BITS-1:0] v);
        return t_q'(v);
    endfunction

    function automatic logic [WORD_BITS-1:0] fix_const(int k);
        return WORD_BITS'(64'(k) << FRAC_BITS);
    endfunction

    function automatic t_qres out_word(t_q x);
        t_qres r;
        t_q    hi;
        t_q    wmax;
        wmax  = t_q'((65'd1 << (WORD_BITS - 1)) - 65'd1);
        hi    = x >>> (WORD_BITS - 1);
        r.sat = 1'b0;
        r.v   = x;
        if (hi != '0 && hi != '1) begin
            r.sat = 1'b1;
            r.v   = x[63] ? ~wmax : wmax;
        end
        return r;
    endfunction

    // ---------------- configuration ----------------
    logic [WORD_BITS-1:0] r_cfg [NUM_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[REG_FOCAL_X]  <= fix_const(K_FOCAL);
            r_cfg[REG_FOCAL_Y]  <= fix_const(K_FOCAL);
            r_cfg[REG_CENTER_X] <= fix_const(K_CENTER_X);
            r_cfg[REG_CENTER_Y] <= fix_const(K_CENTER_Y);
            r_cfg[REG_CAMERA_X] <= '0;
            r_cfg[REG_CAMERA_Y] <= '0;
            r_cfg[REG_CAMERA_Z] <= fix_const(K_CAMERA_Z);
        end else if (i_cfg_we && (i_cfg_idx < 3'(NUM_REGS))) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    t_q c_fx, c_fy, c_cx, c_cy, c_tx, c_ty, c_tz;
    assign c_fx = sx(r_cfg[REG_FOCAL_X]);
    assign c_fy = sx(r_cfg[REG_FOCAL_Y]);
    assign c_cx = sx(r_cfg[REG_CENTER_X]);
    assign c_cy = sx(r_cfg[REG_CENTER_Y]);
    assign c_tx = sx(r_cfg[REG_CAMERA_X]);
    assign c_ty = sx(r_cfg[REG_CAMERA_Y]);
    assign c_tz = sx(r_cfg[REG_CAMERA_Z]);

    // ---------------- flow control ----------------
    logic           en;
    logic [NST-1:0] r_vld;

    assign en              = !r_vld[NST-1] || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_s_axis_tvalid};
        end
    end

    // ---------------- arithmetic stages ----------------
    t_ctx n_in, r_in;
    t_ctx n_a1, r_a1, n_a2, r_a2, n_a3, r_a3, n_a4, r_a4;
    t_ctx n_a5, r_a5, n_a6, r_a6, n_a7, r_a7, n_a8, r_a8;
    t_ctx r_d1 [3];
    t_ctx r_d2 [3];
    t_ctx r_d3 [3];
    t_ctx r_d4 [3];

    t_q   m1_a [4], m1_b [4], m1_p [4];
    logic m1_s [4];
    t_q   m2_a [18], m2_b [18], m2_p [18];
    logic m2_s [18];
    t_q   m3_a [6], m3_b [6], m3_p [6];
    logic m3_s [6];
    t_q   m4_a [6], m4_b [6], m4_p [6];
    logic m4_s [6];

    for (genvar g = 0; g < 4; g++) begin : g_m1
        ilrp_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul (
            .i_clk(i_clk), .i_en(en), .i_a(m1_a[g]), .i_b(m1_b[g]),
            .o_p(m1_p[g]), .o_sat(m1_s[g])
        );
    end
    for (genvar g = 0; g < 18; g++) begin : g_m2
        ilrp_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul (
            .i_clk(i_clk), .i_en(en), .i_a(m2_a[g]), .i_b(m2_b[g]),
            .o_p(m2_p[g]), .o_sat(m2_s[g])
        );
    end
    for (genvar g = 0; g < 6; g++) begin : g_m3
        ilrp_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul (
            .i_clk(i_clk), .i_en(en), .i_a(m3_a[g]), .i_b(m3_b[g]),
            .o_p(m3_p[g]), .o_sat(m3_s[g])
        );
    end
    for (genvar g = 0; g < 6; g++) begin : g_m4
        ilrp_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul (
            .i_clk(i_clk), .i_en(en), .i_a(m4_a[g]), .i_b(m4_b[g]),
            .o_p(m4_p[g]), .o_sat(m4_s[g])
        );
    end

    always_comb begin
        n_in     = '0;
        n_in.a   = sx(i_s_axis_tdata[0*WORD_BITS +: WORD_BITS]);
        n_in.b   = sx(i_s_axis_tdata[1*WORD_BITS +: WORD_BITS]);
        n_in.c   = sx(i_s_axis_tdata[2*WORD_BITS +: WORD_BITS]);
        n_in.q0  = sx(i_s_axis_tdata[3*WORD_BITS +: WORD_BITS]);
        n_in.q1  = sx(i_s_axis_tdata[4*WORD_BITS +: WORD_BITS]);
        n_in.q2  = sx(i_s_axis_tdata[5*WORD_BITS +: WORD_BITS]);
        n_in.off = sx(i_s_axis_tdata[6*WORD_BITS +: WORD_BITS]);
    end

    // back-projection K^T l
    always_comb begin
        m1_a[0] = c_fx; m1_b[0] = r_in.a;
        m1_a[1] = c_fy; m1_b[1] = r_in.b;
        m1_a[2] = c_cx; m1_b[2] = r_in.a;
        m1_a[3] = c_cy; m1_b[3] = r_in.b;
    end

    always_comb begin
        t_qres r0, r1;
        r0        = qneg(m1_p[1]);
        r1        = qadd(m1_p[2], m1_p[3]);
        n_a1      = r_d1[2];
        n_a1.p0   = m1_p[0];
        n_a1.p2   = r0.v;
        n_a1.p1   = r1.v;
        n_a1.sat  = r_d1[2].sat | m1_s[0] | m1_s[1] | m1_s[2] | m1_s[3] | r0.sat | r1.sat;
    end

    always_comb begin
        t_qres r0;
        r0       = qadd(r_a1.p1, r_a1.c);
        n_a2     = r_a1;
        n_a2.p1  = r0.v;
        n_a2.sat = r_a1.sat | r0.sat;
    end

    // world-frame plane p = (pc0, pc2, -pc1) against the road plane
    always_comb begin
        m2_a[0]  = c_tx;    m2_b[0]  = r_a2.p0;
        m2_a[1]  = c_ty;    m2_b[1]  = r_a2.p1;
        m2_a[2]  = c_tz;    m2_b[2]  = r_a2.p2;
        m2_a[3]  = r_a2.p1; m2_b[3]  = r_a2.q2;
        m2_a[4]  = r_a2.p2; m2_b[4]  = r_a2.q1;
        m2_a[5]  = r_a2.p2; m2_b[5]  = r_a2.q0;
        m2_a[6]  = r_a2.p0; m2_b[6]  = r_a2.q2;
        m2_a[7]  = r_a2.p0; m2_b[7]  = r_a2.q1;
        m2_a[8]  = r_a2.p1; m2_b[8]  = r_a2.q0;
        m2_a[9]  = r_a2.p0; m2_b[9]  = r_a2.p0;
        m2_a[10] = r_a2.p1; m2_b[10] = r_a2.p1;
        m2_a[11] = r_a2.p2; m2_b[11] = r_a2.p2;
        m2_a[12] = r_a2.p0; m2_b[12] = r_a2.q0;
        m2_a[13] = r_a2.p1; m2_b[13] = r_a2.q1;
        m2_a[14] = r_a2.p2; m2_b[14] = r_a2.q2;
        m2_a[15] = r_a2.q0; m2_b[15] = r_a2.q0;
        m2_a[16] = r_a2.q1; m2_b[16] = r_a2.q1;
        m2_a[17] = r_a2.q2; m2_b[17] = r_a2.q2;
    end

    always_comb begin
        t_qres r0, r1, r2, r3, r4, r5, r6;
        logic  s;
        s  = r_d2[2].sat;
        for (int k = 0; k < 18; k++) begin
            s = s | m2_s[k];
        end
        r0 = qadd(m2_p[0], m2_p[1]);
        r1 = qsub(m2_p[3], m2_p[4]);
        r2 = qsub(m2_p[5], m2_p[6]);
        r3 = qsub(m2_p[7], m2_p[8]);
        r4 = qadd(m2_p[9], m2_p[10]);
        r5 = qadd(m2_p[12], m2_p[13]);
        r6 = qadd(m2_p[15], m2_p[16]);
        n_a3     = r_d2[2];
        n_a3.tp  = r0.v;
        n_a3.d0  = r1.v;
        n_a3.d1  = r2.v;
        n_a3.d2  = r3.v;
        n_a3.pp  = r4.v;
        n_a3.pq  = r5.v;
        n_a3.qq  = r6.v;
        // third terms of the dot products, added next stage
        n_a3.e0  = m2_p[2];
        n_a3.e1  = m2_p[11];
        n_a3.e2  = m2_p[14];
        n_a3.e3  = m2_p[17];
        n_a3.sat = s | r0.sat | r1.sat | r2.sat | r3.sat | r4.sat | r5.sat | r6.sat;
    end

    always_comb begin
        t_qres r0, r1, r2, r3, r4, r5, r6;
        r0 = qadd(r_a3.tp, r_a3.e0);
        r1 = qadd(r_a3.pp, r_a3.e1);
        r2 = qadd(r_a3.pq, r_a3.e2);
        r3 = qadd(r_a3.qq, r_a3.e3);
        r4 = out_word(r_a3.d0);
        r5 = out_word(r_a3.d1);
        r6 = out_word(r_a3.d2);
        n_a4     = r_a3;
        n_a4.tp  = r0.v;
        n_a4.pp  = r1.v;
        n_a4.pq  = r2.v;
        n_a4.qq  = r3.v;
        n_a4.d0  = r4.v;
        n_a4.d1  = r5.v;
        n_a4.d2  = r6.v;
        n_a4.sat = r_a3.sat | r0.sat | r1.sat | r2.sat | r3.sat | r4.sat | r5.sat | r6.sat;
    end

    always_comb begin
        t_qres r0, r1;
        r0       = qneg(r_a4.tp);
        r1       = qneg(r_a4.off);
        n_a5     = r_a4;
        n_a5.tp  = r0.v;
        n_a5.b1  = r1.v;
        n_a5.sat = r_a4.sat | r0.sat | r1.sat;
    end

    always_comb begin
        t_qres r0;
        r0       = qneg(r_a5.tp);
        n_a6     = r_a5;
        n_a6.b0  = r0.v;
        n_a6.sat = r_a5.sat | r0.sat;
    end

    // Gram matrix terms
    always_comb begin
        m3_a[0] = r_a6.qq; m3_b[0] = r_a6.b0;
        m3_a[1] = r_a6.pq; m3_b[1] = r_a6.b1;
        m3_a[2] = r_a6.pp; m3_b[2] = r_a6.b1;
        m3_a[3] = r_a6.pq; m3_b[3] = r_a6.b0;
        m3_a[4] = r_a6.pp; m3_b[4] = r_a6.qq;
        m3_a[5] = r_a6.pq; m3_b[5] = r_a6.pq;
    end

    always_comb begin
        t_qres r0, r1, r2;
        logic  s;
        s  = r_d3[2].sat;
        for (int k = 0; k < 6; k++) begin
            s = s | m3_s[k];
        end
        r0 = qsub(m3_p[0], m3_p[1]);
        r1 = qsub(m3_p[2], m3_p[3]);
        r2 = qsub(m3_p[4], m3_p[5]);
        n_a7     = r_d3[2];
        n_a7.s0  = r0.v;
        n_a7.s1  = r1.v;
        n_a7.det = r2.v;
        n_a7.par = r2.v == '0;
        n_a7.sat = s | r0.sat | r1.sat | r2.sat;
    end

    always_comb begin
        m4_a[0] = r_a7.p0; m4_b[0] = r_a7.s0;
        m4_a[1] = r_a7.q0; m4_b[1] = r_a7.s1;
        m4_a[2] = r_a7.p1; m4_b[2] = r_a7.s0;
        m4_a[3] = r_a7.q1; m4_b[3] = r_a7.s1;
        m4_a[4] = r_a7.p2; m4_b[4] = r_a7.s0;
        m4_a[5] = r_a7.q2; m4_b[5] = r_a7.s1;
    end

    always_comb begin
        t_qres r0, r1, r2;
        logic  s;
        s  = 1'b0;
        for (int k = 0; k < 6; k++) begin
            s = s | m4_s[k];
        end
        r0 = qadd(m4_p[0], m4_p[1]);
        r1 = qadd(m4_p[2], m4_p[3]);
        r2 = qadd(m4_p[4], m4_p[5]);
        n_a8     = r_d4[2];
        n_a8.n0  = r0.v;
        n_a8.n1  = r1.v;
        n_a8.n2  = r2.v;
        // with parallel planes the point is forced to zero, so its flags do not count
        n_a8.sat = r_d4[2].sat | (!r_d4[2].par & (s | r0.sat | r1.sat | r2.sat));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in    <= n_in;
            r_d1[0] <= r_in;
            r_d1[1] <= r_d1[0];
            r_d1[2] <= r_d1[1];
            r_a1    <= n_a1;
            r_a2    <= n_a2;
            r_d2[0] <= r_a2;
            r_d2[1] <= r_d2[0];
            r_d2[2] <= r_d2[1];
            r_a3    <= n_a3;
            r_a4    <= n_a4;
            r_a5    <= n_a5;
            r_a6    <= n_a6;
            r_d3[0] <= r_a6;
            r_d3[1] <= r_d3[0];
            r_d3[2] <= r_d3[1];
            r_a7    <= n_a7;
            r_d4[0] <= r_a7;
            r_d4[1] <= r_d4[0];
            r_d4[2] <= r_d4[1];
            r_a8    <= n_a8;
        end
    end

    // ---------------- dividers: restoring, one quotient bit per stage ----------------
    t_tail                n_dp_tail;
    logic [DIV_STEPS-1:0] n_dp_div [3];
    t_tail                r_tail [DIV_STEPS+1];
    logic [63:0]          r_rem  [DIV_STEPS+1][3];
    logic [DIV_STEPS-1:0] r_quo  [DIV_STEPS+1][3];
    logic [DIV_STEPS-1:0] r_div  [DIV_STEPS+1][3];
    logic [63:0]          n_rem  [DIV_STEPS][3];
    logic [DIV_STEPS-1:0] n_quo  [DIV_STEPS][3];
    logic [DIV_STEPS-1:0] n_div  [DIV_STEPS][3];

    always_comb begin
        n_dp_tail.d0     = r_a8.d0;
        n_dp_tail.d1     = r_a8.d1;
        n_dp_tail.d2     = r_a8.d2;
        n_dp_tail.ud     = magn(r_a8.det);
        n_dp_tail.neg[0] = r_a8.n0[63] ^ r_a8.det[63];
        n_dp_tail.neg[1] = r_a8.n1[63] ^ r_a8.det[63];
        n_dp_tail.neg[2] = r_a8.n2[63] ^ r_a8.det[63];
        n_dp_tail.sat    = r_a8.sat;
        n_dp_tail.par    = r_a8.par;
        n_dp_div[0]      = {magn(r_a8.n0), FRAC_BITS'(0)};
        n_dp_div[1]      = {magn(r_a8.n1), FRAC_BITS'(0)};
        n_dp_div[2]      = {magn(r_a8.n2), FRAC_BITS'(0)};
    end

    always_comb begin
        logic [64:0] trial;
        logic        ge;
        for (int k = 0; k < DIV_STEPS; k++) begin
            for (int l = 0; l < 3; l++) begin
                trial       = {r_rem[k][l], r_div[k][l][DIV_STEPS-1]};
                ge          = trial >= {1'b0, r_tail[k].ud};
                n_rem[k][l] = ge ? 64'(trial - {1'b0, r_tail[k].ud}) : trial[63:0];
                n_quo[k][l] = {r_quo[k][l][DIV_STEPS-2:0], ge};
                n_div[k][l] = r_div[k][l] << 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tail[0] <= n_dp_tail;
            for (int l = 0; l < 3; l++) begin
                r_rem[0][l] <= '0;
                r_quo[0][l] <= '0;
                r_div[0][l] <= n_dp_div[l];
            end
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_tail[k+1] <= r_tail[k];
                for (int l = 0; l < 3; l++) begin
                    r_rem[k+1][l] <= n_rem[k][l];
                    r_quo[k+1][l] <= n_quo[k][l];
                    r_div[k+1][l] <= n_div[k][l];
                end
            end
        end
    end

    // ---------------- rounding and output ----------------
    logic [DIV_STEPS:0]  n_r1_q [3];
    logic [DIV_STEPS:0]  r_r1_q [3];
    t_tail               r_r1_tail;
    logic [OUT_BITS-1:0] n_out, r_out;

    always_comb begin
        logic [63:0] rem;
        logic [63:0] ud;
        ud = r_tail[DIV_STEPS].ud;
        for (int l = 0; l < 3; l++) begin
            rem       = r_rem[DIV_STEPS][l];
            // round half away from zero on the magnitude
            n_r1_q[l] = {1'b0, r_quo[DIV_STEPS][l]} + (DIV_STEPS + 1)'(rem >= ud - rem);
        end
    end

    always_comb begin
        t_qres       rq;
        t_qres       ow;
        logic        s;
        logic [1:0]  status;
        t_q          pt [3];
        s = r_r1_tail.sat;
        for (int l = 0; l < 3; l++) begin
            if (|r_r1_q[l][DIV_STEPS:64]) begin
                rq.v   = r_r1_tail.neg[l] ? Q_MIN : Q_MAX;
                rq.sat = 1'b1;
            end else begin
                rq = from_mag(r_r1_tail.neg[l], r_r1_q[l][63:0]);
            end
            ow    = out_word(rq.v);
            pt[l] = r_r1_tail.par ? '0 : ow.v;
            s     = s | (!r_r1_tail.par & (rq.sat | ow.sat));
        end
        status = r_r1_tail.par ? ST_PARALLEL : (s ? ST_SAT : ST_OK);
        n_out  = '0;
        n_out[0*WORD_BITS +: WORD_BITS] = r_r1_tail.d0[WORD_BITS-1:0];
        n_out[1*WORD_BITS +: WORD_BITS] = r_r1_tail.d1[WORD_BITS-1:0];
        n_out[2*WORD_BITS +: WORD_BITS] = r_r1_tail.d2[WORD_BITS-1:0];
        n_out[3*WORD_BITS +: WORD_BITS] = pt[0][WORD_BITS-1:0];
        n_out[4*WORD_BITS +: WORD_BITS] = pt[1][WORD_BITS-1:0];
        n_out[5*WORD_BITS +: WORD_BITS] = pt[2][WORD_BITS-1:0];
        n_out[6*WORD_BITS +: 2]         = status;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                r_r1_q[l] <= n_r1_q[l];
            end
            r_r1_tail <= r_tail[DIV_STEPS];
            r_out     <= n_out;
        end
    end

    assign o_m_axis_tdata = r_out;

    // ---------------- checks ----------------
    `ILRP_ASSERT_NEXT(a_stall_holds_valid, i_clk, i_rst_n, !en, $stable(r_vld))
    `ILRP_ASSERT_SAME(a_parallel_zero_point, i_clk, i_rst_n, o_m_axis_tvalid && (o_m_axis_tdata[6*WORD_BITS +: 2] == ST_PARALLEL), o_m_axis_tdata[3*WORD_BITS +: 3*WORD_BITS] == '0)
    `ILRP_ASSERT_SAME(a_status_code, i_clk, i_rst_n, o_m_axis_tvalid, (o_m_axis_tdata[6*WORD_BITS +: 2] == ST_OK) || (o_m_axis_tdata[6*WORD_BITS +: 2] == ST_PARALLEL) || (o_m_axis_tdata[6*WORD_BITS +: 2] == ST_SAT))

endmodule
